### rtl/pf_pkg.sv
`timescale 1ns / 1ps

package pf_pkg;

   localparam int GRID_SIDE    = 5;
   localparam int CELL_COUNT   = GRID_SIDE * GRID_SIDE;
   localparam int LETTER_COUNT = 26;

   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_X = 5'd23;
   localparam logic [4:0] LETTER_Z = 5'd25;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_FINISH  = 2'd1,
      REQ_ENCRYPT = 2'd2,
      REQ_NONE    = 2'd3
   } pf_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EQUAL     = 2'd1,
      STATUS_NOT_READY = 2'd2
   } pf_status_type;

   typedef enum logic [2:0] {
      PF_IDLE,
      PF_FILL,
      PF_POS_A,
      PF_POS_B,
      PF_CALC,
      PF_CELL_B,
      PF_RESP
   } pf_state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] first_letter;
      logic [4:0] second_letter;
      logic       second_present;
   } pf_req_type;

   typedef struct packed {
      logic [4:0] cipher_first;
      logic [4:0] cipher_second;
      logic [1:0] status;
   } pf_rsp_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } pf_pos_type;

   typedef struct packed {
      logic       cell_we;
      logic [4:0] cell_addr;
      logic [4:0] cell_data;
      logic       pos_we;
      logic [4:0] pos_addr;
      pf_pos_type pos_data;
   } pf_wr_type;

   typedef struct packed {
      logic       cell_re;
      logic [4:0] cell_addr;
      logic       pos_re;
      logic [4:0] pos_addr;
   } pf_rd_type;

   // Saturates codes above Z and folds J into I.
   function automatic logic [4:0] norm_letter(input logic [4:0] raw);
      logic [4:0] v;
      v = (raw > LETTER_Z) ? LETTER_Z : raw;
      if (v == LETTER_J) begin
         v = LETTER_I;
      end
      return v;
   endfunction

   function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
      return {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] v);
      return (v == 3'(GRID_SIDE - 1)) ? 3'd0 : v + 3'd1;
   endfunction

endpackage

### rtl/pf_store.sv
`timescale 1ns / 1ps

module pf_store
   import pf_pkg::*;
(
   input  logic       clock,
   input  pf_wr_type  wr,
   input  pf_rd_type  rd,
   output logic [4:0] cell_rdata,
   output pf_pos_type pos_rdata
);

   logic [4:0] cell_mem [CELL_COUNT];
   pf_pos_type pos_mem  [LETTER_COUNT];
   logic [4:0] cell_rdata_ff;
   pf_pos_type pos_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.cell_we) begin
         cell_mem[wr.cell_addr] <= wr.cell_data;
      end
      if (wr.pos_we) begin
         pos_mem[wr.pos_addr] <= wr.pos_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.cell_re) begin
         cell_rdata_ff <= cell_mem[rd.cell_addr];
      end
      if (rd.pos_re) begin
         pos_rdata_ff <= pos_mem[rd.pos_addr];
      end
   end

   assign cell_rdata = cell_rdata_ff;
   assign pos_rdata  = pos_rdata_ff;

endmodule

### rtl/pf_seq.sv
`timescale 1ns / 1ps

module pf_seq
   import pf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  pf_req_type req_data,
   input  logic       rsp_free,
   output logic       rsp_load,
   output pf_rsp_type rsp_next,
   output pf_wr_type  wr,
   output pf_rd_type  rd,
   input  logic [4:0] cell_rdata,
   input  pf_pos_type pos_rdata
);

   pf_state_type  state_ff, state_in;
   logic [25:0]   used_ff, used_in;
   logic [4:0]    fill_count_ff, fill_count_in;
   logic [2:0]    fill_row_ff, fill_row_in;
   logic [2:0]    fill_col_ff, fill_col_in;
   logic          ready_ff, ready_in;
   logic [4:0]    walk_ff, walk_in;
   logic [4:0]    a_ff, a_in;
   logic [4:0]    b_ff, b_in;
   pf_pos_type    pa_ff, pa_in;
   logic [4:0]    idx_b_ff, idx_b_in;
   logic [4:0]    first_ff, first_in;
   pf_status_type status_ff, status_in;

   logic       accept;
   logic       place_en;
   logic [4:0] place_letter;
   logic       place_go;
   logic [4:0] enc_a;
   logic [4:0] enc_b;
   logic [2:0] ra, ca, rb, cb;

   assign req_ready = (state_ff == PF_IDLE);
   assign accept    = req_valid && req_ready;
   assign enc_a     = norm_letter(req_data.first_letter);
   assign enc_b     = req_data.second_present ? norm_letter(req_data.second_letter) : LETTER_X;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PF_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_FINISH && !ready_ff) begin
                  state_in = PF_FILL;
               end else if (req_data.req_type == REQ_ENCRYPT) begin
                  if (!ready_ff || enc_a == enc_b) begin
                     state_in = PF_RESP;
                  end else begin
                     state_in = PF_POS_A;
                  end
               end
            end
         end
         PF_FILL: begin
            if (walk_ff == LETTER_Z) begin
               state_in = PF_IDLE;
            end
         end
         PF_POS_A:  state_in = PF_POS_B;
         PF_POS_B:  state_in = PF_CALC;
         PF_CALC:   state_in = PF_CELL_B;
         PF_CELL_B: state_in = PF_RESP;
         PF_RESP: begin
            if (rsp_free) begin
               state_in = PF_IDLE;
            end
         end
         default:   state_in = PF_IDLE;
      endcase
   end

   always_comb begin
      used_in       = used_ff;
      fill_count_in = fill_count_ff;
      fill_row_in   = fill_row_ff;
      fill_col_in   = fill_col_ff;
      ready_in      = ready_ff;
      walk_in       = walk_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pa_in         = pa_ff;
      idx_b_in      = idx_b_ff;
      first_in      = first_ff;
      status_in     = status_ff;
      place_en      = 1'b0;
      place_letter  = walk_ff;
      rd            = '0;
      rsp_load      = 1'b0;
      ra            = pa_ff.row;
      ca            = pa_ff.col;
      rb            = pos_rdata.row;
      cb            = pos_rdata.col;

      unique case (state_ff)
         PF_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_ADD: begin
                     place_en     = !ready_ff;
                     place_letter = enc_a;
                  end
                  REQ_FINISH: begin
                     walk_in = 5'd0;
                  end
                  REQ_ENCRYPT: begin
                     a_in     = enc_a;
                     b_in     = enc_b;
                     first_in = 5'd0;
                     if (!ready_ff) begin
                        status_in = STATUS_NOT_READY;
                     end else if (enc_a == enc_b) begin
                        status_in = STATUS_EQUAL;
                     end else begin
                        status_in = STATUS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         PF_FILL: begin
            place_en     = (walk_ff != LETTER_J);
            place_letter = walk_ff;
            walk_in      = walk_ff + 5'd1;
            if (walk_ff == LETTER_Z) begin
               ready_in = 1'b1;
            end
         end
         PF_POS_A: begin
            rd.pos_re   = 1'b1;
            rd.pos_addr = a_ff;
         end
         PF_POS_B: begin
            pa_in       = pos_rdata;
            rd.pos_re   = 1'b1;
            rd.pos_addr = b_ff;
         end
         PF_CALC: begin
            if (pa_ff.row == pos_rdata.row) begin
               ca = wrap_inc(pa_ff.col);
               cb = wrap_inc(pos_rdata.col);
            end else if (pa_ff.col == pos_rdata.col) begin
               ra = wrap_inc(pa_ff.row);
               rb = wrap_inc(pos_rdata.row);
            end else begin
               ca = pos_rdata.col;
               cb = pa_ff.col;
            end
            rd.cell_re   = 1'b1;
            rd.cell_addr = cell_index(ra, ca);
            idx_b_in     = cell_index(rb, cb);
         end
         PF_CELL_B: begin
            first_in     = cell_rdata;
            rd.cell_re   = 1'b1;
            rd.cell_addr = idx_b_ff;
         end
         PF_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase

      place_go = place_en && !used_ff[place_letter] && (fill_count_ff < 5'(CELL_COUNT));

      if (place_go) begin
         used_in[place_letter] = 1'b1;
         fill_count_in         = fill_count_ff + 5'd1;
         if (fill_col_ff == 3'(GRID_SIDE - 1)) begin
            fill_col_in = 3'd0;
            fill_row_in = fill_row_ff + 3'd1;
         end else begin
            fill_col_in = fill_col_ff + 3'd1;
         end
      end
   end

   assign wr.cell_we   = place_go;
   assign wr.cell_addr = fill_count_ff;
   assign wr.cell_data = place_letter;
   assign wr.pos_we    = place_go;
   assign wr.pos_addr  = place_letter;
   assign wr.pos_data  = '{row: fill_row_ff, col: fill_col_ff};

   assign rsp_next.cipher_first  = first_ff;
   assign rsp_next.cipher_second = (status_ff == STATUS_OK) ? cell_rdata : 5'd0;
   assign rsp_next.status        = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PF_IDLE;
         used_ff       <= '0;
         fill_count_ff <= '0;
         fill_row_ff   <= '0;
         fill_col_ff   <= '0;
         ready_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         fill_count_ff <= fill_count_in;
         fill_row_ff   <= fill_row_in;
         fill_col_ff   <= fill_col_in;
         ready_ff      <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff   <= walk_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      pa_ff     <= pa_in;
      idx_b_ff  <= idx_b_in;
      first_ff  <= first_in;
      status_ff <= status_in;
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(fill_count_ff))
      else $error("Letter-used bits disagree with the fill count.");

   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (fill_count_ff == 5'(CELL_COUNT)))
      else $error("Square marked ready before every cell was filled.");

   assert property (@(posedge clock) disable iff (reset)
      !used_ff[LETTER_J])
      else $error("The letter J was placed in the square.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> ($past(state_ff) == PF_FILL))
      else $error("Square became ready outside the fill walk.");
`endif

endmodule

### rtl/playfair_digraph_encrypt_core.sv
`timescale 1ns / 1ps
// An added key letter is placed as it is accepted, if unused; the block stays ready.
// Finishing the square walks the 26 letters through the shared placement unit.
// An encrypt request steps through PF_POS_A, PF_POS_B, PF_CALC and PF_CELL_B (two position
// reads, two cell reads); PF_RESP loads the output register and then returns to PF_IDLE.
// A flagged encrypt goes straight to PF_RESP; a full output register holds the block there.
// Synchronous active-high reset clears the square state and the output valid flag; no sweep.

module playfair_digraph_encrypt_core
   import pf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  pf_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output pf_rsp_type rsp_data
);

   pf_wr_type  wr;
   pf_rd_type  rd;
   logic [4:0] cell_rdata;
   pf_pos_type pos_rdata;
   logic       rsp_free;
   logic       rsp_load;
   pf_rsp_type rsp_next;
   logic       rsp_valid_ff, rsp_valid_in;
   pf_rsp_type rsp_data_ff;

   pf_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd         (rd),
      .cell_rdata (cell_rdata),
      .pos_rdata  (pos_rdata)
   );

   pf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp_next   (rsp_next),
      .wr         (wr),
      .rd         (rd),
      .cell_rdata (cell_rdata),
      .pos_rdata  (pos_rdata)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
